@@ hdl/lmcs_pkg.sv @@
// Shared types, constants and font table for the LED matrix character scanner.
`default_nettype none
package lmcs_pkg;

    localparam int ROWS   = 8;
    localparam int ROW_W  = 3;
    localparam int FRAMES = 2;
    localparam int LAYERS = 2;
    localparam int PLANES = FRAMES * LAYERS;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_SCAN  = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [1:0] COLOR_GREEN = 2'd0;
    localparam logic [1:0] COLOR_RED   = 2'd1;

    localparam logic [7:0] CHAR_FIRST = 8'h41;
    localparam logic [7:0] CHAR_LAST  = 8'h5a;
    localparam logic [3:0] OFFSET_MAX = 4'd8;

    typedef struct packed {
        logic       rotate;
        logic       load;
        logic       frame;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } lmcs_store_ctrl_t;

    typedef struct packed {
        logic [7:0] f0_green;
        logic [7:0] f0_red;
        logic [7:0] f1_green;
        logic [7:0] f1_red;
    } lmcs_heads_t;

    // Glyph rows 6..0, row 0 in the low byte.
    function automatic logic [55:0] font_glyph(input logic [4:0] idx);
        logic [55:0] g;
        unique case (idx)
            5'd0:  g = 56'hcc_cc_cc_fc_cc_78_30;
            5'd1:  g = 56'hf8_cc_cc_f8_cc_cc_f8;
            5'd2:  g = 56'h78_cc_c0_c0_c0_cc_78;
            5'd3:  g = 56'hf0_d8_cc_cc_cc_d8_f0;
            5'd4:  g = 56'hfc_c0_c0_f0_c0_c0_fc;
            5'd5:  g = 56'hc0_c0_c0_f0_c0_c0_fc;
            5'd6:  g = 56'h78_cc_cc_dc_c0_cc_78;
            5'd7:  g = 56'hcc_cc_cc_fc_cc_cc_cc;
            5'd8:  g = 56'h78_30_30_30_30_30_78;
            5'd9:  g = 56'h70_d8_18_18_18_18_3c;
            5'd10: g = 56'hcc_d8_f0_e0_f0_d8_cc;
            5'd11: g = 56'hfc_c0_c0_c0_c0_c0_c0;
            5'd12: g = 56'hc6_c6_c6_d6_fe_ee_c6;
            5'd13: g = 56'hcc_cc_dc_fc_fc_ec_cc;
            5'd14: g = 56'h78_cc_cc_cc_cc_cc_78;
            5'd15: g = 56'hc0_c0_c0_f8_cc_cc_f8;
            5'd16: g = 56'h0c_78_cc_cc_cc_cc_78;
            5'd17: g = 56'hcc_d8_f0_f8_cc_cc_f8;
            5'd18: g = 56'h78_cc_0c_78_c0_cc_78;
            5'd19: g = 56'h30_30_30_30_30_30_fc;
            5'd20: g = 56'h78_cc_cc_cc_cc_cc_cc;
            5'd21: g = 56'h30_78_cc_cc_cc_cc_cc;
            5'd22: g = 56'hc6_de_fe_d6_c6_c6_c6;
            5'd23: g = 56'hcc_cc_78_30_78_cc_cc;
            5'd24: g = 56'h30_30_30_78_cc_cc_cc;
            5'd25: g = 56'hfc_c0_60_30_18_0c_fc;
            default: g = 56'h0;
        endcase
        return g;
    endfunction

    // Row of a letter glyph; blank for row 7 and for non-letters.
    function automatic logic [7:0] font_row(input logic [7:0] code, input logic [ROW_W-1:0] row);
        logic [7:0]  idx;
        logic [55:0] g;
        logic [7:0]  r;
        idx = code - CHAR_FIRST;
        g   = font_glyph(idx[4:0]);
        r   = 8'h00;
        if (code >= CHAR_FIRST && code <= CHAR_LAST && row != ROW_W'(ROWS - 1)) begin
            r = g[{row, 3'b000} +: 8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/lmcs_frame_store.sv @@
// Frame store: four row planes that shift or rotate one row per step.
`default_nettype none
module lmcs_frame_store (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lmcs_pkg::lmcs_store_ctrl_t ctrl,
    output lmcs_pkg::lmcs_heads_t           heads
);

    // plane index = frame * 2 + layer, layer 0 green
    logic [lmcs_pkg::PLANES-1:0][lmcs_pkg::ROWS-1:0][7:0] plane_reg;
    logic [lmcs_pkg::PLANES-1:0][lmcs_pkg::ROWS-1:0][7:0] plane_next;

    always_comb begin
        plane_next = plane_reg;
        for (int p = 0; p < lmcs_pkg::PLANES; p++) begin
            if (ctrl.rotate || (ctrl.load && (p / lmcs_pkg::LAYERS) == int'(ctrl.frame))) begin
                for (int i = 0; i < lmcs_pkg::ROWS - 1; i++) begin
                    plane_next[p][i] = plane_reg[p][i+1];
                end
                if (ctrl.rotate) begin
                    plane_next[p][lmcs_pkg::ROWS-1] = plane_reg[p][0];
                end else if ((p % lmcs_pkg::LAYERS) == 0) begin
                    plane_next[p][lmcs_pkg::ROWS-1] = ctrl.green_in;
                end else begin
                    plane_next[p][lmcs_pkg::ROWS-1] = ctrl.red_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else begin
            plane_reg <= plane_next;
        end
    end

    assign heads.f0_green = plane_reg[0][0];
    assign heads.f0_red   = plane_reg[1][0];
    assign heads.f1_green = plane_reg[2][0];
    assign heads.f1_red   = plane_reg[3][0];

endmodule
`default_nettype wire

@@ hdl/lmcs_blend.sv @@
// Scroll blend unit shared by all rows of a refresh.
`default_nettype none
module lmcs_blend (
    input  wire logic [3:0]            offset,
    input  wire lmcs_pkg::lmcs_heads_t heads,
    output logic [7:0]                 green_row,
    output logic [7:0]                 red_row
);

    logic [3:0]  off_sat;
    logic [3:0]  off_inv;
    logic [15:0] g_left;
    logic [15:0] r_left;

    always_comb begin
        off_sat   = (offset > lmcs_pkg::OFFSET_MAX) ? lmcs_pkg::OFFSET_MAX : offset;
        off_inv   = lmcs_pkg::OFFSET_MAX - off_sat;
        g_left    = {8'h00, heads.f0_green} << off_sat;
        r_left    = {8'h00, heads.f0_red} << off_sat;
        green_row = g_left[7:0] | (heads.f1_green >> off_inv);
        red_row   = r_left[7:0] | (heads.f1_red >> off_inv);
    end

endmodule
`default_nettype wire

@@ hdl/led_matrix_char_scanner_top.sv @@
// Top level of the LED matrix character scanner: sequencer and stream ports.
// A write, clear or refresh item occupies the block while a three-bit row
// counter steps through the eight matrix rows; s_tready is low meanwhile.
// A write or clear loads eight rows into the chosen frame, one row a cycle.
// A refresh rotates all planes past the shared blend unit and emits one row
// word per cycle while m_tready is high; a stalled output word holds the scan.
// Function code three is taken and does nothing.
`default_nettype none
module led_matrix_char_scanner_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // char_code[7:0], frame_sel[8], color_sel[10:9]
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // row_select[7:0], green_row[15:8], red_row[23:16]
    output logic             m_tlast,
    input  wire logic        cfg_wen,
    input  wire logic [3:0]  cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    localparam logic [lmcs_pkg::ROW_W-1:0] ROW_END = lmcs_pkg::ROW_W'(lmcs_pkg::ROWS - 1);

    logic [1:0]                  state_reg, state_next;
    logic [lmcs_pkg::ROW_W-1:0]  cnt_reg, cnt_next;
    logic [3:0]                  offset_reg;
    logic                        draw_reg;
    logic [7:0]                  code_reg;
    logic                        frame_reg;
    logic [1:0]                  color_reg;
    logic                        m_tvalid_reg;
    logic [23:0]                 m_tdata_reg;
    logic                        m_tlast_reg;

    logic                        accept;
    logic                        scan_step;
    logic [7:0]                  glyph_row;
    logic [7:0]                  green_row;
    logic [7:0]                  red_row;
    lmcs_pkg::lmcs_store_ctrl_t  ctrl;
    lmcs_pkg::lmcs_heads_t       heads;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign scan_step = (state_reg == ST_SCAN) && (!m_tvalid_reg || m_tready);
    assign glyph_row = draw_reg ? lmcs_pkg::font_row(code_reg, cnt_reg) : 8'h00;

    always_comb begin
        ctrl.rotate   = scan_step;
        ctrl.load     = (state_reg == ST_LOAD);
        ctrl.frame    = frame_reg;
        ctrl.green_in = (color_reg != lmcs_pkg::COLOR_RED) ? glyph_row : 8'h00;
        ctrl.red_in   = (color_reg != lmcs_pkg::COLOR_GREEN) ? glyph_row : 8'h00;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    unique case (s_tuser)
                        lmcs_pkg::FUNC_WRITE, lmcs_pkg::FUNC_CLEAR: state_next = ST_LOAD;
                        lmcs_pkg::FUNC_SCAN: state_next = ST_SCAN;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ROW_END) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_step) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == ROW_END) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            offset_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wen) begin
                offset_reg <= cfg_wdata;
            end
            if (scan_step) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            draw_reg  <= (s_tuser == lmcs_pkg::FUNC_WRITE);
            code_reg  <= s_tdata[7:0];
            frame_reg <= s_tdata[8];
            color_reg <= s_tdata[10:9];
        end
        if (scan_step) begin
            m_tdata_reg <= {red_row, green_row, 8'(8'd1 << cnt_reg)};
            m_tlast_reg <= (cnt_reg == ROW_END);
        end
    end

    lmcs_frame_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .heads   (heads)
    );

    lmcs_blend u_blend (
        .offset    (offset_reg),
        .heads     (heads),
        .green_row (green_row),
        .red_row   (red_row)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

@@ hdl/lmcs_checker.sv @@
// Port-level checks for the LED matrix character scanner, bound to the top level.
`default_nettype none
module lmcs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    a_row_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[7:0]))
        else $error("row select not one-hot");

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tdata[7]))
        else $error("last flag does not match final row");

    a_idle_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("ready while a refresh is unfinished");

endmodule

bind led_matrix_char_scanner_top lmcs_checker u_lmcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
